### src/balanced_queue_pair_macros.svh
// Assertion helpers for the balanced queue pair.
`ifndef BALANCED_QUEUE_PAIR_MACROS_SVH
`define BALANCED_QUEUE_PAIR_MACROS_SVH

// Same-cycle implication, checked out of reset.
`define BQP_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("bqp assertion failed");

// Next-cycle implication, checked out of reset.
`define BQP_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("bqp assertion failed");

`endif

### src/bqp_pkg.sv
package bqp_pkg;

    localparam int ACTION_W    = 2;
    localparam int VALUE_W     = 32;
    localparam int EVENT_W     = 3;
    localparam int COUNT_W     = 5;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 5;
    localparam int LIMIT_W     = 4;
    localparam int REFILL_W    = 5;

    localparam logic [LIMIT_W-1:0]  OVERFLOW_LIMIT_RST     = 4'd10;
    localparam logic [LIMIT_W-1:0]  PARTNER_ROOM_LIMIT_RST = 4'd9;
    localparam logic [REFILL_W-1:0] REFILL_MIN_RST         = 5'd2;

    typedef enum logic [ACTION_W-1:0] {
        ACT_PUSH_FIRST,
        ACT_PUSH_SECOND,
        ACT_POP_FIRST,
        ACT_POP_SECOND
    } action_t;

    typedef enum logic [EVENT_W-1:0] {
        EV_NONE,
        EV_SPILL,
        EV_FULL,
        EV_REFILL,
        EV_EMPTY,
        EV_UNDER,
        EV_DROP
    } event_t;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_OVERFLOW_LIMIT,
        CFG_PARTNER_ROOM_LIMIT,
        CFG_REFILL_MIN
    } cfg_index_t;

    typedef struct packed {
        logic [LIMIT_W-1:0]  overflow_limit;
        logic [LIMIT_W-1:0]  partner_room_limit;
        logic [REFILL_W-1:0] refill_min;
    } limits_t;

    // per-cycle queue operation: push goes to the tail, pop drops the head
    typedef struct packed {
        logic push;
        logic pop;
    } fifo_op_t;

endpackage

### src/bqp_if.sv
interface bqp_req_if;
    logic                                valid;
    logic                                ready;
    logic [bqp_pkg::ACTION_W-1:0]        action;
    logic signed [bqp_pkg::VALUE_W-1:0]  push_value;

    modport source (output valid, action, push_value, input ready);
    modport sink   (input valid, action, push_value, output ready);
endinterface

interface bqp_rsp_if;
    logic                                valid;
    logic                                ready;
    logic signed [bqp_pkg::VALUE_W-1:0]  pop_value;
    logic                                pop_valid;
    logic [bqp_pkg::EVENT_W-1:0]         event_res;
    logic                                event_queue;
    logic [bqp_pkg::COUNT_W-1:0]         first_count;
    logic [bqp_pkg::COUNT_W-1:0]         second_count;

    modport source (output valid, pop_value, pop_valid, event_res, event_queue,
                    first_count, second_count, input ready);
    modport sink   (input valid, pop_value, pop_valid, event_res, event_queue,
                    first_count, second_count, output ready);
endinterface

interface bqp_cfg_if;
    logic                                valid;
    logic                                ready;
    logic [bqp_pkg::CFG_INDEX_W-1:0]     index;
    logic [bqp_pkg::CFG_DATA_W-1:0]      data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

### src/bqp_fifo.sv
module bqp_fifo #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32,
    parameter int PTR_W      = $clog2(DEPTH),
    parameter int SIZE_W     = $clog2(DEPTH + 1)
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  bqp_pkg::fifo_op_t     op,
    input  logic [DATA_WIDTH-1:0] push_data,
    output logic [DATA_WIDTH-1:0] head_data,
    output logic [SIZE_W-1:0]     size,
    output logic [SIZE_W-1:0]     size_next
);

    localparam logic [PTR_W:0]   DEPTH_P = (PTR_W + 1)'(DEPTH);
    localparam logic [PTR_W-1:0] LAST    = PTR_W'(DEPTH - 1);

    logic [DATA_WIDTH-1:0] mem_reg [DEPTH];
    logic [DATA_WIDTH-1:0] head_data_reg;
    logic [PTR_W-1:0]      head_reg;
    logic [PTR_W-1:0]      head_next;
    logic [SIZE_W-1:0]     size_reg;
    logic [PTR_W:0]        tail_sum;
    logic [PTR_W-1:0]      tail_addr;

    // tail is taken from the state before this cycle's pop
    assign tail_sum  = {1'b0, head_reg} + (PTR_W + 1)'(size_reg);
    assign tail_addr = (tail_sum >= DEPTH_P) ? PTR_W'(tail_sum - DEPTH_P) : PTR_W'(tail_sum);

    always_comb
    begin
        head_next = head_reg;
        if (op.pop)
        begin
            head_next = (head_reg == LAST) ? '0 : head_reg + 1'b1;
        end
        case ({op.push, op.pop})
            2'b10:   size_next = size_reg + 1'b1;
            2'b01:   size_next = size_reg - 1'b1;
            default: size_next = size_reg;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg <= '0;
            size_reg <= '0;
        end
        else
        begin
            head_reg <= head_next;
            size_reg <= size_next;
        end
    end

    // head word is prefetched every cycle; a write to the new head slot bypasses
    always_ff @(posedge clk)
    begin
        if (op.push)
        begin
            mem_reg[tail_addr] <= push_data;
        end
        if (op.push && tail_addr == head_next)
        begin
            head_data_reg <= push_data;
        end
        else
        begin
            head_data_reg <= mem_reg[head_next];
        end
    end

    assign head_data = head_data_reg;
    assign size      = size_reg;

endmodule

### src/bqp_cfg_regs.sv
module bqp_cfg_regs (
    input  logic              clk,
    input  logic              rst_n,
    bqp_cfg_if.sink           cfg,
    output bqp_pkg::limits_t  limits
);

    bqp_pkg::limits_t limits_reg;

    assign cfg.ready = 1'b1;
    assign limits    = limits_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            limits_reg.overflow_limit     <= bqp_pkg::OVERFLOW_LIMIT_RST;
            limits_reg.partner_room_limit <= bqp_pkg::PARTNER_ROOM_LIMIT_RST;
            limits_reg.refill_min         <= bqp_pkg::REFILL_MIN_RST;
        end
        else if (cfg.valid)
        begin
            case (bqp_pkg::cfg_index_t'(cfg.index))
                bqp_pkg::CFG_OVERFLOW_LIMIT:
                    limits_reg.overflow_limit <= cfg.data[bqp_pkg::LIMIT_W-1:0];
                bqp_pkg::CFG_PARTNER_ROOM_LIMIT:
                    limits_reg.partner_room_limit <= cfg.data[bqp_pkg::LIMIT_W-1:0];
                bqp_pkg::CFG_REFILL_MIN:
                    limits_reg.refill_min <= cfg.data[bqp_pkg::REFILL_W-1:0];
                default:
                    ;
            endcase
        end
    end

endmodule

### src/balanced_queue_pair.sv
// A word's result goes from the input register into the output register once that is free.
// Throughput: one word per cycle while the response side does not stall; each queue updates
// head, size and its prefetched head word (registered read of the queue memory) together.
// Reset (async, active low): both queues empty, limits back to 10 / 9 / 2.
// Queue memories are not cleared; no clearing pass, the block is ready right out of reset.
`include "balanced_queue_pair_macros.svh"

module balanced_queue_pair #(
    parameter int DEPTH      = 16,
    parameter int DATA_WIDTH = 32
) (
    input logic       clk,
    input logic       rst_n,
    bqp_req_if.sink   req,
    bqp_rsp_if.source rsp,
    bqp_cfg_if.sink   cfg
);

    localparam int SIZE_W = $clog2(DEPTH + 1);
    localparam logic [SIZE_W-1:0] DEPTH_S = SIZE_W'(DEPTH);

    bqp_pkg::limits_t   limits;

    // input register
    logic                           in_valid_reg;
    bqp_pkg::action_t               action_reg;
    logic [bqp_pkg::VALUE_W-1:0]    push_value_reg;

    // output register
    logic                           out_valid_reg;
    logic [bqp_pkg::VALUE_W-1:0]    pop_value_reg;
    logic                           pop_valid_reg;
    bqp_pkg::event_t                event_res_reg;
    logic                           event_queue_reg;
    logic [bqp_pkg::COUNT_W-1:0]    first_count_reg;
    logic [bqp_pkg::COUNT_W-1:0]    second_count_reg;

    logic                           exec;
    logic                           q_sel;
    logic                           is_pop;

    bqp_pkg::fifo_op_t              a_op, b_op;
    bqp_pkg::fifo_op_t              first_op, second_op;
    logic [DATA_WIDTH-1:0]          a_data, b_data;
    logic [DATA_WIDTH-1:0]          first_data, second_data;
    logic [DATA_WIDTH-1:0]          first_head, second_head;
    logic [DATA_WIDTH-1:0]          a_head, b_head;
    logic [DATA_WIDTH-1:0]          push_ext;
    logic [SIZE_W-1:0]              first_size, second_size;
    logic [SIZE_W-1:0]              first_size_next, second_size_next;
    logic [SIZE_W-1:0]              a_size, b_size;
    logic [SIZE_W:0]                a_size_inc;
    logic [DATA_WIDTH-1:0]          pop_val;
    logic                           pop_vld;
    bqp_pkg::event_t                ev;
    logic [SIZE_W:0]                total_size;
    logic                           sizes_in_range;
    logic                           push_kept;
    logic                           under_seen;

    bqp_cfg_regs u_cfg (
        .clk    (clk),
        .rst_n  (rst_n),
        .cfg    (cfg),
        .limits (limits)
    );

    bqp_fifo #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_first (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (first_op),
        .push_data (first_data),
        .head_data (first_head),
        .size      (first_size),
        .size_next (first_size_next)
    );

    bqp_fifo #(
        .DEPTH      (DEPTH),
        .DATA_WIDTH (DATA_WIDTH)
    ) u_second (
        .clk       (clk),
        .rst_n     (rst_n),
        .op        (second_op),
        .push_data (second_data),
        .head_data (second_head),
        .size      (second_size),
        .size_next (second_size_next)
    );

    assign exec      = in_valid_reg && (!out_valid_reg || rsp.ready);
    assign req.ready = !in_valid_reg || exec;

    assign q_sel  = (action_reg == bqp_pkg::ACT_PUSH_SECOND) ||
                    (action_reg == bqp_pkg::ACT_POP_SECOND);
    assign is_pop = (action_reg == bqp_pkg::ACT_POP_FIRST) ||
                    (action_reg == bqp_pkg::ACT_POP_SECOND);

    assign a_size     = q_sel ? second_size : first_size;
    assign b_size     = q_sel ? first_size : second_size;
    assign a_head     = q_sel ? second_head : first_head;
    assign b_head     = q_sel ? first_head : second_head;
    assign a_size_inc = {1'b0, a_size} + 1'b1;
    assign push_ext   = DATA_WIDTH'(push_value_reg);

    // a = addressed queue, b = partner
    always_comb
    begin
        a_op    = '0;
        b_op    = '0;
        a_data  = push_ext;
        b_data  = a_head;
        ev      = bqp_pkg::EV_NONE;
        pop_val = '0;
        pop_vld = 1'b0;
        if (!is_pop)
        begin
            if (a_size == DEPTH_S)
            begin
                ev = bqp_pkg::EV_DROP;
            end
            else
            begin
                a_op.push = 1'b1;
                if (a_size_inc > limits.overflow_limit)
                begin
                    if (b_size < limits.partner_room_limit && b_size != DEPTH_S)
                    begin
                        a_op.pop  = 1'b1;
                        b_op.push = 1'b1;
                        // with an empty queue the spilled head is the word just pushed
                        b_data    = (a_size == '0) ? push_ext : a_head;
                        ev        = bqp_pkg::EV_SPILL;
                    end
                    else
                    begin
                        ev = bqp_pkg::EV_FULL;
                    end
                end
            end
        end
        else
        begin
            if (a_size == '0)
            begin
                ev = bqp_pkg::EV_UNDER;
            end
            else
            begin
                a_op.pop = 1'b1;
                pop_val  = a_head;
                pop_vld  = 1'b1;
                if (a_size == SIZE_W'(1))
                begin
                    if (b_size >= limits.refill_min && b_size != '0)
                    begin
                        b_op.pop  = 1'b1;
                        a_op.push = 1'b1;
                        a_data    = b_head;
                        ev        = bqp_pkg::EV_REFILL;
                    end
                    else
                    begin
                        ev = bqp_pkg::EV_EMPTY;
                    end
                end
            end
        end
    end

    assign first_op    = exec ? (q_sel ? b_op : a_op) : '0;
    assign second_op   = exec ? (q_sel ? a_op : b_op) : '0;
    assign first_data  = q_sel ? b_data : a_data;
    assign second_data = q_sel ? a_data : b_data;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (req.ready)
            begin
                in_valid_reg <= req.valid;
            end
            out_valid_reg <= exec || (out_valid_reg && !rsp.ready);
        end
    end

    always_ff @(posedge clk)
    begin
        if (req.valid && req.ready)
        begin
            action_reg     <= bqp_pkg::action_t'(req.action);
            push_value_reg <= req.push_value;
        end
        if (exec)
        begin
            pop_value_reg    <= bqp_pkg::VALUE_W'(pop_val);
            pop_valid_reg    <= pop_vld;
            event_res_reg    <= ev;
            event_queue_reg  <= (ev == bqp_pkg::EV_NONE) ? 1'b0 : q_sel;
            first_count_reg  <= bqp_pkg::COUNT_W'(first_size_next);
            second_count_reg <= bqp_pkg::COUNT_W'(second_size_next);
        end
    end

    assign rsp.valid        = out_valid_reg;
    assign rsp.pop_value    = pop_value_reg;
    assign rsp.pop_valid    = pop_valid_reg;
    assign rsp.event_res    = event_res_reg;
    assign rsp.event_queue  = event_queue_reg;
    assign rsp.first_count  = first_count_reg;
    assign rsp.second_count = second_count_reg;

    assign total_size     = {1'b0, first_size} + {1'b0, second_size};
    assign sizes_in_range = first_size <= DEPTH_S && second_size <= DEPTH_S;
    assign push_kept      = exec && !is_pop && ev != bqp_pkg::EV_DROP;
    assign under_seen     = exec && ev == bqp_pkg::EV_UNDER;

    `BQP_ASSERT_NOW(a_size_bound, clk, rst_n, 1'b1, sizes_in_range)
    `BQP_ASSERT_NEXT(a_push_adds_one, clk, rst_n, push_kept, total_size == $past(total_size) + 1'b1)
    `BQP_ASSERT_NEXT(a_under_keeps, clk, rst_n, under_seen, total_size == $past(total_size))
    `BQP_ASSERT_NOW(a_pop_has_word, clk, rst_n, exec && pop_vld, is_pop && a_size != '0)

endmodule

### tb/bqp_outcome_checker.sv
`timescale 1ns / 1ps

// Watches the three channels, keeps its own copy of both queues and the limits,
// and compares every response word with the outcome predicted for its request.
module bqp_outcome_checker
    import bqp_pkg::*;
#(
    parameter int DEPTH = 16
) (
    input  logic clk,
    input  logic rst_n,
    bqp_req_if   req,
    bqp_rsp_if   rsp,
    bqp_cfg_if   cfg,
    output int   mismatches,
    output int   in_flight
);

    typedef struct packed {
        logic [VALUE_W-1:0] pop_value;
        logic               pop_valid;
        event_t             event_res;
        logic               event_queue;
        logic [COUNT_W-1:0] first_count;
        logic [COUNT_W-1:0] second_count;
    } outcome_t;

    // index 0 is the first queue, 1 the second
    logic [VALUE_W-1:0] slots [2][DEPTH];
    int unsigned        head [2];
    int unsigned        fill [2];
    limits_t            limits;
    outcome_t           expected_outcomes [$];

    function automatic void enqueue(int q, logic [VALUE_W-1:0] word);
        slots[q][(head[q] + fill[q]) % DEPTH] = word;
        fill[q]++;
    endfunction

    function automatic logic [VALUE_W-1:0] dequeue(int q);
        logic [VALUE_W-1:0] word;
        word = slots[q][head[q]];
        head[q] = (head[q] + 1) % DEPTH;
        fill[q]--;
        return word;
    endfunction

    function automatic outcome_t balance_step(action_t act, logic [VALUE_W-1:0] word);
        outcome_t res;
        int       own;
        int       other;
        event_t   ev;
        own   = (act == ACT_PUSH_SECOND || act == ACT_POP_SECOND) ? 1 : 0;
        other = 1 - own;
        ev    = EV_NONE;
        res   = '0;
        if (act == ACT_PUSH_FIRST || act == ACT_PUSH_SECOND)
        begin
            if (fill[own] >= DEPTH)
                ev = EV_DROP;
            else
            begin
                enqueue(own, word);
                if (fill[own] > limits.overflow_limit)
                begin
                    if (fill[other] < limits.partner_room_limit && fill[other] < DEPTH)
                    begin
                        enqueue(other, dequeue(own));
                        ev = EV_SPILL;
                    end
                    else
                        ev = EV_FULL;
                end
            end
        end
        else if (fill[own] == 0)
            ev = EV_UNDER;
        else
        begin
            res.pop_value = dequeue(own);
            res.pop_valid = 1'b1;
            if (fill[own] == 0)
            begin
                // refill never takes from an empty partner, even with refill_min at 0
                if (fill[other] >= limits.refill_min && fill[other] > 0)
                begin
                    enqueue(own, dequeue(other));
                    ev = EV_REFILL;
                end
                else
                    ev = EV_EMPTY;
            end
        end
        res.event_res    = ev;
        res.event_queue  = (ev != EV_NONE) ? own[0] : 1'b0;
        res.first_count  = fill[0][COUNT_W-1:0];
        res.second_count = fill[1][COUNT_W-1:0];
        return res;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin
        outcome_t want;
        if (!rst_n)
        begin
            head       = '{0, 0};
            fill       = '{0, 0};
            limits     = '{OVERFLOW_LIMIT_RST, PARTNER_ROOM_LIMIT_RST, REFILL_MIN_RST};
            mismatches = 0;
            expected_outcomes.delete();
            in_flight <= 0;
        end
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    CFG_OVERFLOW_LIMIT:     limits.overflow_limit     = cfg.data[LIMIT_W-1:0];
                    CFG_PARTNER_ROOM_LIMIT: limits.partner_room_limit = cfg.data[LIMIT_W-1:0];
                    CFG_REFILL_MIN:         limits.refill_min         = cfg.data[REFILL_W-1:0];
                    default: ;
                endcase
            end
            if (req.valid && req.ready)
                expected_outcomes.push_back(balance_step(action_t'(req.action),
                                                         req.push_value));
            if (rsp.valid && rsp.ready)
            begin
                if (expected_outcomes.size() == 0)
                begin
                    mismatches++;
                    $display("%0t: unexpected word, pop_value %h event %0d",
                             $time, rsp.pop_value, rsp.event_res);
                end
                else
                begin
                    want = expected_outcomes.pop_front();
                    if (rsp.pop_value !== want.pop_value)
                    begin
                        mismatches++;
                        $display("%0t: pop_value expected %h got %h",
                                 $time, want.pop_value, rsp.pop_value);
                    end
                    if (rsp.pop_valid !== want.pop_valid)
                    begin
                        mismatches++;
                        $display("%0t: pop_valid expected %b got %b",
                                 $time, want.pop_valid, rsp.pop_valid);
                    end
                    if (rsp.event_res !== want.event_res)
                    begin
                        mismatches++;
                        $display("%0t: event_res expected %0d got %0d",
                                 $time, want.event_res, rsp.event_res);
                    end
                    if (rsp.event_queue !== want.event_queue)
                    begin
                        mismatches++;
                        $display("%0t: event_queue expected %b got %b",
                                 $time, want.event_queue, rsp.event_queue);
                    end
                    if (rsp.first_count !== want.first_count)
                    begin
                        mismatches++;
                        $display("%0t: first_count expected %0d got %0d",
                                 $time, want.first_count, rsp.first_count);
                    end
                    if (rsp.second_count !== want.second_count)
                    begin
                        mismatches++;
                        $display("%0t: second_count expected %0d got %0d",
                                 $time, want.second_count, rsp.second_count);
                    end
                end
            end
            in_flight <= expected_outcomes.size();
        end
    end

endmodule

### tb/tb_balanced_queue_pair.sv
`timescale 1ns / 1ps

module tb_balanced_queue_pair;
    import bqp_pkg::*;

    localparam int IDLE_LIMIT       = 5000;
    localparam int HOLD_CYCLES      = 60;
    localparam int RANDOM_PER_PHASE = 104;
    localparam int PHASES           = 8;

    logic clk   = 1'b0;
    logic rst_n = 1'b0;

    bqp_req_if req_ch ();
    bqp_rsp_if rsp_ch ();
    bqp_cfg_if cfg_ch ();

    int   mismatches;
    int   in_flight;
    int   idle_cycles = 0;
    int   burst_left;
    bit   steady;
    logic hold_armed;

    int push_mix  [5] = '{10, 35, 55, 75, 95};
    int first_mix [3] = '{10, 50, 90};
    int stall_mix [5] = '{0, 0, 20, 50, 80};

    // limits per random phase; the last two phases draw their own
    int phase_overflow [6] = '{10, 15, 1, 1, 15, 7};
    int phase_room     [6] = '{9, 1, 15, 1, 15, 4};
    int phase_refill   [6] = '{2, 1, 16, 1, 16, 3};

    balanced_queue_pair dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    bqp_outcome_checker #(.DEPTH(16)) outcome_check (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req_ch),
        .rsp        (rsp_ch),
        .cfg        (cfg_ch),
        .mismatches (mismatches),
        .in_flight  (in_flight)
    );

    always
    begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rst_n && !(req_ch.valid && req_ch.ready) && !(rsp_ch.valid && rsp_ch.ready)
            && !(cfg_ch.valid && cfg_ch.ready))
            idle_cycles++;
        else
            idle_cycles = 0;
        if (idle_cycles >= IDLE_LIMIT)
        begin
            $display("Simulation FAILED");
            $finish;
        end
    end

    // response side: stall rate changes per window, one long hold-off when armed
    initial
    begin
        int stall_pct;
        int window;
        bit hold_done;
        rsp_ch.ready = 1'b0;
        stall_pct    = 0;
        window       = 0;
        hold_done    = 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_armed && !hold_done)
            begin
                hold_done = 1'b1;
                rsp_ch.ready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            if (window == 0)
            begin
                window    = $urandom_range(80, 20);
                stall_pct = stall_mix[$urandom_range(4, 0)];
            end
            window--;
            rsp_ch.ready <= ($urandom_range(99, 0) >= stall_pct);
        end
    end

    task automatic offer(action_t act, logic [VALUE_W-1:0] word);
        int gap;
        if (burst_left == 0)
        begin
            gap        = (steady || $urandom_range(9, 0) < 4) ? 0 : $urandom_range(6, 1);
            burst_left = $urandom_range(12, 1);
            if (gap > 0)
            begin
                req_ch.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        req_ch.valid      <= 1'b1;
        req_ch.action     <= act;
        req_ch.push_value <= word;
        do @(posedge clk); while (req_ch.ready !== 1'b1);
    endtask

    // stop sending and wait until every response word is back
    task automatic drain();
        req_ch.valid <= 1'b0;
        @(posedge clk);
        while (in_flight != 0) @(posedge clk);
        repeat (4) @(posedge clk);
        burst_left = 0;
    endtask

    task automatic write_reg(cfg_index_t idx, logic [CFG_DATA_W-1:0] value);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.data  <= value;
        do @(posedge clk); while (cfg_ch.ready !== 1'b1);
        cfg_ch.valid <= 1'b0;
        @(posedge clk);
    endtask

    task automatic set_limits(int overflow, int room, int refill);
        write_reg(CFG_OVERFLOW_LIMIT, CFG_DATA_W'(overflow));
        write_reg(CFG_PARTNER_ROOM_LIMIT, CFG_DATA_W'(room));
        write_reg(CFG_REFILL_MIN, CFG_DATA_W'(refill));
    endtask

    task automatic run_random(int count);
        int                 push_pct;
        int                 first_pct;
        bit                 to_first;
        action_t            act;
        logic [VALUE_W-1:0] word;
        push_pct  = 50;
        first_pct = 50;
        for (int n = 0; n < count; n++)
        begin
            // shift the push/pop balance every few words to reach full and empty
            if (n % 25 == 0)
            begin
                push_pct  = push_mix[$urandom_range(4, 0)];
                first_pct = first_mix[$urandom_range(2, 0)];
            end
            to_first = ($urandom_range(99, 0) < first_pct);
            if ($urandom_range(99, 0) < push_pct)
                act = to_first ? ACT_PUSH_FIRST : ACT_PUSH_SECOND;
            else
                act = to_first ? ACT_POP_FIRST : ACT_POP_SECOND;
            case ($urandom_range(7, 0))
                0:       word = 32'h7FFF_FFFF;
                1:       word = 32'h8000_0000;
                2:       word = '1;
                3:       word = '0;
                default: word = $urandom;
            endcase
            offer(act, word);
        end
    endtask

    initial
    begin
        req_ch.valid      = 1'b0;
        req_ch.action     = ACT_PUSH_FIRST;
        req_ch.push_value = '0;
        cfg_ch.valid      = 1'b0;
        cfg_ch.index      = CFG_OVERFLOW_LIMIT;
        cfg_ch.data       = '0;
        burst_left        = 0;
        steady            = 1'b0;
        hold_armed        = 1'b0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // reset limits 10 / 9 / 2: underflow, empty, refill, extreme values
        offer(ACT_POP_FIRST, '0);
        offer(ACT_POP_SECOND, '1);
        offer(ACT_PUSH_FIRST, 32'h7FFF_FFFF);
        offer(ACT_POP_FIRST, '0);
        offer(ACT_PUSH_FIRST, 32'h8000_0000);
        offer(ACT_PUSH_SECOND, '0);
        offer(ACT_PUSH_SECOND, '1);
        offer(ACT_POP_FIRST, '0);
        offer(ACT_POP_SECOND, '0);
        offer(ACT_POP_FIRST, '0);

        // spill both ways
        drain();
        set_limits(1, 15, 16);
        offer(ACT_PUSH_FIRST, 32'h5555_5555);
        offer(ACT_PUSH_FIRST, 32'hAAAA_AAAA);
        offer(ACT_PUSH_SECOND, 32'h0000_FFFF);

        // partner too full to take a spill
        drain();
        write_reg(CFG_PARTNER_ROOM_LIMIT, CFG_DATA_W'(1));
        offer(ACT_PUSH_FIRST, 32'hFFFF_0000);

        // refill_min of zero, ending with an empty partner
        drain();
        write_reg(CFG_REFILL_MIN, CFG_DATA_W'(0));
        offer(ACT_POP_SECOND, '0);
        offer(ACT_POP_SECOND, '0);
        offer(ACT_POP_FIRST, '0);
        offer(ACT_POP_FIRST, '0);

        for (int p = 0; p < PHASES; p++)
        begin
            drain();
            if (p < 6)
                set_limits(phase_overflow[p], phase_room[p], phase_refill[p]);
            else
                set_limits($urandom_range(15, 1), $urandom_range(15, 1),
                           $urandom_range(16, 0));
            // back-to-back words against a long response hold-off
            if (p == 5)
            begin
                steady = 1'b1;
                hold_armed <= 1'b1;
            end
            run_random(RANDOM_PER_PHASE);
            steady = 1'b0;
        end

        drain();
        repeat (8) @(posedge clk);
        if (mismatches == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

### filelist.f
+incdir+src
src/bqp_pkg.sv
src/bqp_if.sv
src/bqp_fifo.sv
src/bqp_cfg_regs.sv
src/balanced_queue_pair.sv
tb/bqp_outcome_checker.sv
tb/tb_balanced_queue_pair.sv
